@@ rtl/core/adc2w_pkg.sv @@
// shared types and constants for the two-wire converter master
`timescale 1ns / 1ps

package adc2w_pkg;

  localparam int unsigned IN_W  = 16;  // packed input transfer width
  localparam int unsigned OUT_W = 40;  // packed result transfer width

  localparam logic [7:0] CMD_WRITE = 8'h65;
  localparam logic [7:0] CMD_READ  = 8'h56;
  localparam logic [7:0] CFG_KEEP  = 8'hC3;
  localparam logic [7:0] CFG_RESET = 8'h0C;

  localparam logic [5:0] READ_CLOCKS = 6'd27;
  localparam logic [5:0] CMD_CLOCKS  = 6'd46;
  localparam logic [5:0] DIR_CLOCK   = 6'd37;
  localparam logic [5:0] DATA_FIRST  = 6'd38;
  localparam logic [5:0] DATA_LAST   = 6'd45;
  localparam logic [5:0] CMD_FIRST   = 6'd28;
  localparam logic [5:0] CMD_DUP     = 6'd29;
  localparam logic [5:0] CMD_LAST    = 6'd36;

  typedef enum logic [1:0] {
    OP_READ_SAMPLE = 2'd0,
    OP_WRITE_CFG   = 2'd1,
    OP_READ_CFG    = 2'd2,
    OP_SET_RATE    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_LOW  = 4'b1000
  } phase_e;

endpackage

@@ rtl/core/adc_two_wire_serial_master_core.sv @@
// two-wire serial master for a 24-bit sigma-delta converter, one tick per transfer
`timescale 1ns / 1ps

// Each input transfer is one tick of the serial sequencer and gives exactly one
// result transfer, which appears in the output register in the cycle after the
// input transfer; a new tick is taken every cycle while the output register is
// empty or being drained, so the sustained rate is one tick per clock cycle.
// The serial clock period is 2 * half_period_ticks ticks (0 acts as 1). A
// sample read waits for the data pin to go low, then gives READ_CLOCKS clocks;
// configuration commands run on to CMD_CLOCKS. The configuration register may
// only be written while no command is in progress.
module adc_two_wire_serial_master_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: start_req[0], opcode[2:1], write_value[10:3], rate[12:11],
  //        gain[14:13], pin_level[15]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [adc2w_pkg::IN_W-1:0]    s_axis_tdata,
  // tdata: serial_clock[0], pin_drive[1], pin_drive_enable[2], busy_res[3],
  //        done_res[4], sample[28:5], config_readback[36:29], data_ready[37],
  //        zero fill[39:38]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [adc2w_pkg::OUT_W-1:0]   m_axis_tdata,
  // half_period_ticks
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [7:0]                    cfg_data_i
);
  import adc2w_pkg::*;

  logic        start;
  op_e         op;
  logic [7:0]  wval;
  logic [1:0]  rate;
  logic [1:0]  gain;
  logic        pin;
  logic        in_fire;

  logic [7:0]  half_q;
  logic [7:0]  hp;
  logic        half_end;

  phase_e      phase_q, phase_d;
  logic [5:0]  edge_q, edge_d;
  logic [7:0]  tick_q, tick_d;
  logic [26:0] shift_q, shift_d;
  logic [7:0]  shadow_q, shadow_d;
  op_e         pend_q, pend_d;
  logic [7:0]  obyte_q, obyte_d;
  logic [23:0] sample_q, sample_d;
  logic [7:0]  rdback_q, rdback_d;
  logic        done;

  logic [7:0]  cmd;
  logic [2:0]  cmd_idx;
  logic [2:0]  byte_idx;
  logic        drv_en, drv_val;

  logic [OUT_W-1:0] out_d, out_q;
  logic             out_valid_q;

  assign start = s_axis_tdata[0];
  assign op    = op_e'(s_axis_tdata[2:1]);
  assign wval  = s_axis_tdata[10:3];
  assign rate  = s_axis_tdata[12:11];
  assign gain  = s_axis_tdata[14:13];
  assign pin   = s_axis_tdata[15];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign hp       = (half_q == 8'd0) ? 8'd1 : half_q;
  assign half_end = ({1'b0, tick_q} + 9'd1) >= {1'b0, hp};

  always_comb begin
    phase_d  = phase_q;
    edge_d   = edge_q;
    tick_d   = tick_q;
    shift_d  = shift_q;
    shadow_d = shadow_q;
    pend_d   = pend_q;
    obyte_d  = obyte_q;
    sample_d = sample_q;
    rdback_d = rdback_q;
    done     = 1'b0;
    if (in_fire) begin
      case (phase_q)
        PH_IDLE: begin
          if (start) begin
            pend_d = op;
            case (op)
              OP_WRITE_CFG: obyte_d = wval;
              OP_SET_RATE:  obyte_d = (shadow_q & CFG_KEEP) | {2'b00, rate, gain, 2'b00};
              default:      obyte_d = 8'd0;
            endcase
            shift_d = '0;
            edge_d  = '0;
            tick_d  = '0;
            phase_d = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!pin) begin
            edge_d  = 6'd1;
            tick_d  = '0;
            phase_d = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (half_end) begin
            // sample on the last high tick of read clocks and config data clocks
            if (edge_q <= READ_CLOCKS ||
                (pend_q == OP_READ_CFG && edge_q >= DATA_FIRST && edge_q <= DATA_LAST)) begin
              shift_d = {shift_q[25:0], pin};
            end
            tick_d  = '0;
            phase_d = PH_LOW;
          end else begin
            tick_d = tick_q + 8'd1;
          end
        end
        PH_LOW: begin
          if (half_end) begin
            tick_d = '0;
            if (edge_q == READ_CLOCKS && pend_q == OP_READ_SAMPLE) begin
              sample_d = shift_q[26:3];
              phase_d  = PH_IDLE;
              done     = 1'b1;
            end else if (edge_q >= CMD_CLOCKS) begin
              if (pend_q == OP_READ_CFG) begin
                rdback_d = shift_q[7:0];
              end else begin
                shadow_d = obyte_q;
              end
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              // leading read of a config command is thrown away
              if (edge_q == READ_CLOCKS) begin
                shift_d = '0;
              end
              edge_d  = edge_q + 6'd1;
              phase_d = PH_HIGH;
            end
          end else begin
            tick_d = tick_q + 8'd1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // data pin drive, from the state after this tick
  assign cmd      = (pend_d == OP_READ_CFG) ? CMD_READ : CMD_WRITE;
  assign cmd_idx  = 3'(CMD_LAST - edge_d);
  assign byte_idx = 3'(DATA_LAST - edge_d);

  always_comb begin
    drv_en  = 1'b0;
    drv_val = 1'b0;
    if ((phase_d == PH_HIGH || phase_d == PH_LOW) && pend_d != OP_READ_SAMPLE) begin
      if (edge_d == CMD_FIRST || edge_d == CMD_DUP) begin
        drv_en  = 1'b1;
        drv_val = cmd[6];
      end else if (edge_d > CMD_DUP && edge_d <= CMD_LAST) begin
        drv_en  = 1'b1;
        drv_val = cmd[cmd_idx];
      end else if (edge_d == DIR_CLOCK) begin
        if (pend_d != OP_READ_CFG) begin
          drv_en  = 1'b1;
          drv_val = cmd[0];
        end
      end else if (edge_d >= DATA_FIRST && edge_d <= DATA_LAST) begin
        if (pend_d != OP_READ_CFG) begin
          drv_en  = 1'b1;
          drv_val = obyte_d[byte_idx];
        end
      end
    end
  end

  assign out_d = {2'b00, !pin, rdback_d, sample_d, done, (phase_d != PH_IDLE),
                  drv_en, drv_val, (phase_d == PH_HIGH)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= 8'd1;
      phase_q     <= PH_IDLE;
      edge_q      <= '0;
      tick_q      <= '0;
      shift_q     <= '0;
      shadow_q    <= CFG_RESET;
      pend_q      <= OP_READ_SAMPLE;
      obyte_q     <= '0;
      sample_q    <= '0;
      rdback_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        half_q <= cfg_data_i;
      end
      phase_q  <= phase_d;
      edge_q   <= edge_d;
      tick_q   <= tick_d;
      shift_q  <= shift_d;
      shadow_q <= shadow_d;
      pend_q   <= pend_d;
      obyte_q  <= obyte_d;
      sample_q <= sample_d;
      rdback_q <= rdback_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ rtl/core/adc2w_chk.sv @@
// port-level checks for the two-wire converter master, bound to the top level
`timescale 1ns / 1ps

module adc2w_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [adc2w_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [adc2w_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [7:0]                  cfg_data_i
);

  // every tick transfer lands in the result register on the next edge
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=>
      m_axis_tvalid && (m_axis_tdata[37] == !$past(s_axis_tdata[15])))
    else $error("tick transfer did not produce its result");

  // an empty result register never holds off the input side
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // completion leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
    else $error("done with busy still set");

  // serial clock and pin drive only inside a command
  a_clk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[2]) |-> m_axis_tdata[3])
    else $error("serial clock or drive while idle");

  // released pin reads as zero drive
  a_drive_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2])
    else $error("pin drive level set while released");

endmodule

bind adc_two_wire_serial_master_core adc2w_chk u_adc2w_chk (.*);
